// File: src/afra_pkg.sv
// Shared types and constants of the atlas free-rectangle allocator.
package afra_pkg;

   localparam int SIZE_W = 12;
   localparam int POS_W  = 11;
   localparam int STAT_W = 3;

   localparam logic [SIZE_W-1:0] PAGE_MAX = 12'd2048;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [STAT_W-1:0] STAT_PLACED  = 3'd0;
   localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_OVER    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOFIT   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;
   localparam logic [STAT_W-1:0] STAT_CLEARED = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_WAIT,
      ST_STRIP_R,
      ST_STRIP_B,
      ST_FIN,
      ST_RESP
   } afra_state_type;

   typedef struct packed {
      logic start;
      logic issue;
   } afra_scan_ctl_type;

   typedef struct packed {
      logic busy;
      logic found;
   } afra_scan_sts_type;

endpackage

// File: src/afra_rect_mem.sv
// Free-rectangle store: one write port, one registered read port, whole-page entry zero.
module afra_rect_mem
   import afra_pkg::*;
#(
   parameter int MAX_FREE_RECTS = 256,
   parameter int COORD_BITS     = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                page_clear,
   input  logic [4*COORD_BITS-1:0]             page_rect,
   input  logic                                rd_en,
   input  logic [$clog2(MAX_FREE_RECTS)-1:0]   rd_addr,
   output logic [4*COORD_BITS-1:0]             rd_data,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_FREE_RECTS)-1:0]   wr_addr,
   input  logic [4*COORD_BITS-1:0]             wr_data
);

   localparam int IDX_W  = $clog2(MAX_FREE_RECTS);
   localparam int RECT_W = 4 * COORD_BITS;

   logic [RECT_W-1:0] ram [MAX_FREE_RECTS];
   logic [RECT_W-1:0] ram_q_ff;
   logic              fresh_ff;
   logic              fresh_in;
   logic              ovr_ff;
   logic              ovr_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         ram_q_ff <= ram[rd_addr];
      end
   end

   // Entry zero reads as the whole page until it is first written.
   always_comb begin
      fresh_in = fresh_ff;
      if (wr_en && wr_addr == IDX_W'(0)) begin
         fresh_in = 1'b0;
      end
      if (page_clear) begin
         fresh_in = 1'b1;
      end
      ovr_in = ovr_ff;
      if (rd_en) begin
         ovr_in = fresh_ff && rd_addr == IDX_W'(0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
         ovr_ff   <= 1'b0;
      end else begin
         fresh_ff <= fresh_in;
         ovr_ff   <= ovr_in;
      end
   end

   assign rd_data = ovr_ff ? page_rect : ram_q_ff;

endmodule

// File: src/afra_fit_unit.sv
// Shared fit test, area multiplier and best-area tracker used by the list scan.
module afra_fit_unit
   import afra_pkg::*;
#(
   parameter int MAX_FREE_RECTS = 256,
   parameter int COORD_BITS     = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  afra_scan_ctl_type                   ctl,
   input  logic [$clog2(MAX_FREE_RECTS)-1:0]   issue_idx,
   input  logic [4*COORD_BITS-1:0]             rd_data,
   input  logic [SIZE_W-1:0]                   sprite_width,
   input  logic [SIZE_W-1:0]                   sprite_height,
   output afra_scan_sts_type                   sts,
   output logic [$clog2(MAX_FREE_RECTS)-1:0]   best_idx,
   output logic [4*COORD_BITS-1:0]             best_rect
);

   localparam int IDX_W  = $clog2(MAX_FREE_RECTS);
   localparam int RECT_W = 4 * COORD_BITS;
   localparam int AREA_W = 2 * COORD_BITS;
   localparam int CW     = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;

   logic              v0_ff;
   logic [IDX_W-1:0]  idx0_ff;
   logic              va_ff;
   logic              fita_ff;
   logic [IDX_W-1:0]  idxa_ff;
   logic [RECT_W-1:0] recta_ff;
   logic [AREA_W-1:0] areaa_ff;
   logic              found_ff;
   logic              found_in;
   logic              take;
   logic [AREA_W-1:0] best_area_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [RECT_W-1:0] best_rect_ff;
   logic [COORD_BITS-1:0] rw;
   logic [COORD_BITS-1:0] rh;
   logic              fits;

   assign rw   = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign rh   = rd_data[COORD_BITS-1:0];
   assign fits = (CW'(rw) >= CW'(sprite_width)) && (CW'(rh) >= CW'(sprite_height));

   // Stage a: fit test and area; stage b: keep the smallest, first index wins ties.
   assign take = va_ff && fita_ff && (!found_ff || areaa_ff < best_area_ff);

   always_comb begin
      found_in = found_ff;
      if (ctl.start) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         va_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         v0_ff    <= ctl.issue;
         va_ff    <= v0_ff;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx0_ff <= issue_idx;
      if (v0_ff) begin
         idxa_ff  <= idx0_ff;
         recta_ff <= rd_data;
         fita_ff  <= fits;
         areaa_ff <= AREA_W'(rw) * AREA_W'(rh);
      end
      if (take) begin
         best_area_ff <= areaa_ff;
         best_idx_ff  <= idxa_ff;
         best_rect_ff <= recta_ff;
      end
   end

   assign sts.busy  = v0_ff || va_ff;
   assign sts.found = found_ff;
   assign best_idx  = best_idx_ff;
   assign best_rect = best_rect_ff;

endmodule

// File: src/afra_seq.sv
// Sequencer: item decode, list scan, guillotine split writes and result register.
module afra_seq
   import afra_pkg::*;
#(
   parameter int MAX_FREE_RECTS = 256,
   parameter int COORD_BITS     = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [SIZE_W-1:0]                   req_sprite_width,
   input  logic [SIZE_W-1:0]                   req_sprite_height,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [STAT_W-1:0]                   rsp_status,
   output logic [POS_W-1:0]                    rsp_pos_x,
   output logic [POS_W-1:0]                    rsp_pos_y,
   input  logic                                cfg_clear,
   input  logic [SIZE_W-1:0]                   page_size,
   output logic                                page_clear,
   output afra_scan_ctl_type                   scan_ctl,
   output logic [$clog2(MAX_FREE_RECTS)-1:0]   scan_idx,
   output logic [SIZE_W-1:0]                   sprite_width,
   output logic [SIZE_W-1:0]                   sprite_height,
   input  afra_scan_sts_type                   scan_sts,
   input  logic [$clog2(MAX_FREE_RECTS)-1:0]   best_idx,
   input  logic [4*COORD_BITS-1:0]             best_rect,
   output logic                                rd_en,
   output logic [$clog2(MAX_FREE_RECTS)-1:0]   rd_addr,
   input  logic [4*COORD_BITS-1:0]             rd_data,
   output logic                                wr_en,
   output logic [$clog2(MAX_FREE_RECTS)-1:0]   wr_addr,
   output logic [4*COORD_BITS-1:0]             wr_data
);

   localparam int IDX_W = $clog2(MAX_FREE_RECTS);
   localparam int CNT_W = $clog2(MAX_FREE_RECTS + 1);
   localparam int CW    = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;

   afra_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    c_ff, c_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SIZE_W-1:0]   sw_ff, sw_in;
   logic [SIZE_W-1:0]   sh_ff, sh_in;
   logic [STAT_W-1:0]   stat_ff, stat_in;
   logic [POS_W-1:0]    px_ff, px_in;
   logic [POS_W-1:0]    py_ff, py_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_pos_x_ff, rsp_pos_x_in;
   logic [POS_W-1:0]    rsp_pos_y_ff, rsp_pos_y_in;

   logic [COORD_BITS-1:0] bx, by, bw, bh;
   logic [COORD_BITS-1:0] x_plus, y_plus, w_minus, h_minus, sw_c, sh_c;
   logic                  wdiff, hdiff;
   logic [IDX_W-1:0]      last_idx;

   assign bx = best_rect[4*COORD_BITS-1:3*COORD_BITS];
   assign by = best_rect[3*COORD_BITS-1:2*COORD_BITS];
   assign bw = best_rect[2*COORD_BITS-1:COORD_BITS];
   assign bh = best_rect[COORD_BITS-1:0];

   assign x_plus  = COORD_BITS'(CW'(bx) + CW'(sw_ff));
   assign y_plus  = COORD_BITS'(CW'(by) + CW'(sh_ff));
   assign w_minus = COORD_BITS'(CW'(bw) - CW'(sw_ff));
   assign h_minus = COORD_BITS'(CW'(bh) - CW'(sh_ff));
   assign sw_c    = COORD_BITS'(sw_ff);
   assign sh_c    = COORD_BITS'(sh_ff);
   assign wdiff   = CW'(bw) != CW'(sw_ff);
   assign hdiff   = CW'(bh) != CW'(sh_ff);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      c_in          = c_ff;
      idx_in        = idx_ff;
      sw_in         = sw_ff;
      sh_in         = sh_ff;
      stat_in       = stat_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_x_in  = rsp_pos_x_ff;
      rsp_pos_y_in  = rsp_pos_y_ff;
      req_ready     = 1'b0;
      page_clear    = 1'b0;
      scan_ctl      = '0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = best_idx;
      wr_data       = {x_plus, y_plus, w_minus, h_minus};

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sw_in = req_sprite_width;
               sh_in = req_sprite_height;
               px_in = '0;
               py_in = '0;
               priority if (req_cmd == CMD_CLEAR) begin
                  page_clear = 1'b1;
                  count_in   = CNT_W'(1);
                  stat_in    = STAT_CLEARED;
                  state_in   = ST_RESP;
               end else if (req_sprite_width == '0 || req_sprite_height == '0) begin
                  stat_in  = STAT_ZERO;
                  state_in = ST_RESP;
               end else if (req_sprite_width > page_size || req_sprite_height > page_size) begin
                  stat_in  = STAT_OVER;
                  state_in = ST_RESP;
               end else if (count_ff == '0) begin
                  stat_in  = STAT_NOFIT;
                  state_in = ST_RESP;
               end else begin
                  scan_ctl.start = 1'b1;
                  idx_in         = '0;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_en          = 1'b1;
            scan_ctl.issue = 1'b1;
            if (idx_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!scan_sts.busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // A split on both sides grows the list by two entries.
            priority if (!scan_sts.found) begin
               stat_in  = STAT_NOFIT;
               state_in = ST_RESP;
            end else if (wdiff && hdiff && count_ff >= CNT_W'(MAX_FREE_RECTS - 1)) begin
               stat_in  = STAT_FULL;
               state_in = ST_RESP;
            end else if (wdiff && hdiff) begin
               // Corner remainder takes the chosen slot.
               wr_en    = 1'b1;
               c_in     = count_ff;
               state_in = ST_STRIP_R;
            end else begin
               // Fetch the last entry to move into the chosen slot.
               rd_en    = 1'b1;
               rd_addr  = last_idx;
               c_in     = count_ff - CNT_W'(1);
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            priority if (wdiff) begin
               state_in = ST_STRIP_R;
            end else if (hdiff) begin
               state_in = ST_STRIP_B;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_STRIP_R: begin
            wr_en    = 1'b1;
            wr_addr  = IDX_W'(c_ff);
            wr_data  = {x_plus, by, w_minus, sh_c};
            c_in     = c_ff + CNT_W'(1);
            state_in = hdiff ? ST_STRIP_B : ST_FIN;
         end
         ST_STRIP_B: begin
            wr_en    = 1'b1;
            wr_addr  = IDX_W'(c_ff);
            wr_data  = {bx, y_plus, sw_c, h_minus};
            c_in     = c_ff + CNT_W'(1);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            count_in = c_ff;
            stat_in  = STAT_PLACED;
            px_in    = POS_W'(bx);
            py_in    = POS_W'(by);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_pos_x_in  = px_ff;
               rsp_pos_y_in  = py_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_clear) begin
         count_in = CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff          <= c_in;
      idx_ff        <= idx_in;
      sw_ff         <= sw_in;
      sh_ff         <= sh_in;
      stat_ff       <= stat_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_x_ff  <= rsp_pos_x_in;
      rsp_pos_y_ff  <= rsp_pos_y_in;
   end

   assign scan_idx      = idx_ff;
   assign sprite_width  = sw_ff;
   assign sprite_height = sh_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_pos_x     = rsp_pos_x_ff;
   assign rsp_pos_y     = rsp_pos_y_ff;

endmodule

// File: src/atlas_free_rect_allocator.sv
// Top level of the atlas free-rectangle allocator: page register and block wiring.
//
//   channel   ports                                         direction
//   req       req_valid/ready, req_cmd, req_sprite_w/h       in
//   rsp       rsp_valid/ready, rsp_status, rsp_pos_x/y       out
//   csr       csr_wr_en, csr_wr_data (page_size)             in
//
// Allocate: the scan reads one entry a cycle through the single read port of the
// rectangle store. Clear, zero-size and oversize items skip the scan.
// One item at a time. Reset and a page_size write leave one free rectangle
// covering the page; no clearing pass. A held result stalls only the end of
// the next item.
module atlas_free_rect_allocator
   import afra_pkg::*;
#(
   parameter int MAX_FREE_RECTS = 256,
   parameter int COORD_BITS     = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [SIZE_W-1:0]   req_sprite_width,
   input  logic [SIZE_W-1:0]   req_sprite_height,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [POS_W-1:0]    rsp_pos_x,
   output logic [POS_W-1:0]    rsp_pos_y,
   input  logic                csr_wr_en,
   input  logic [SIZE_W-1:0]   csr_wr_data
);

   localparam int IDX_W  = $clog2(MAX_FREE_RECTS);
   localparam int RECT_W = 4 * COORD_BITS;

   logic [SIZE_W-1:0] page_ff, page_in;
   logic [RECT_W-1:0] page_rect;
   logic              seq_clear;
   logic              page_clear;

   afra_scan_ctl_type scan_ctl;
   afra_scan_sts_type scan_sts;
   logic [IDX_W-1:0]  scan_idx;
   logic [IDX_W-1:0]  best_idx;
   logic [RECT_W-1:0] best_rect;
   logic [SIZE_W-1:0] cur_width;
   logic [SIZE_W-1:0] cur_height;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [RECT_W-1:0] rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [RECT_W-1:0] wr_data;

   // Clamp written page size into one to the page maximum.
   always_comb begin
      page_in = page_ff;
      if (csr_wr_en) begin
         priority if (csr_wr_data == '0) begin
            page_in = SIZE_W'(1);
         end else if (csr_wr_data > PAGE_MAX) begin
            page_in = PAGE_MAX;
         end else begin
            page_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= PAGE_MAX;
      end else begin
         page_ff <= page_in;
      end
   end

   assign page_rect  = {{(2*COORD_BITS){1'b0}}, COORD_BITS'(page_ff), COORD_BITS'(page_ff)};
   assign page_clear = seq_clear || csr_wr_en;

   afra_seq #(
      .MAX_FREE_RECTS (MAX_FREE_RECTS),
      .COORD_BITS     (COORD_BITS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_sprite_width  (req_sprite_width),
      .req_sprite_height (req_sprite_height),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .cfg_clear         (csr_wr_en),
      .page_size         (page_ff),
      .page_clear        (seq_clear),
      .scan_ctl          (scan_ctl),
      .scan_idx          (scan_idx),
      .sprite_width      (cur_width),
      .sprite_height     (cur_height),
      .scan_sts          (scan_sts),
      .best_idx          (best_idx),
      .best_rect         (best_rect),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data)
   );

   afra_fit_unit #(
      .MAX_FREE_RECTS (MAX_FREE_RECTS),
      .COORD_BITS     (COORD_BITS)
   ) u_fit (
      .clock         (clock),
      .reset         (reset),
      .ctl           (scan_ctl),
      .issue_idx     (scan_idx),
      .rd_data       (rd_data),
      .sprite_width  (cur_width),
      .sprite_height (cur_height),
      .sts           (scan_sts),
      .best_idx      (best_idx),
      .best_rect     (best_rect)
   );

   afra_rect_mem #(
      .MAX_FREE_RECTS (MAX_FREE_RECTS),
      .COORD_BITS     (COORD_BITS)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .page_clear (page_clear),
      .page_rect  (page_rect),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

endmodule

// File: verif/tb.sv
// Self-checking testbench for the atlas free-rectangle allocator.
module tb
   import afra_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RECT_SLOTS     = 256;
   localparam int DIRECTED_COUNT = 25;
   localparam int PLAN_COUNT     = 10;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [SIZE_W-1:0] x;
      logic [SIZE_W-1:0] y;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
   } free_rect_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
   } placement_type;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      logic              given;
      placement_type     want;
   } probe_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_cmd = CMD_ALLOC;
   logic [SIZE_W-1:0] req_sprite_width = '0;
   logic [SIZE_W-1:0] req_sprite_height = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [POS_W-1:0]  rsp_pos_x;
   logic [POS_W-1:0]  rsp_pos_y;
   logic              csr_wr_en = 1'b0;
   logic [SIZE_W-1:0] csr_wr_data = '0;

   // predicted state of the page
   free_rect_type     free_list [RECT_SLOTS];
   int                free_total;
   logic [SIZE_W-1:0] page_side;

   placement_type     awaited_q [$];
   probe_row_type     directed_rows [DIRECTED_COUNT];
   logic [SIZE_W-1:0] page_plan [PLAN_COUNT];
   bit                eager = 1'b0;
   int                faults = 0;
   int                quiet_cycles = 0;

   atlas_free_rect_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_sprite_width  (req_sprite_width),
      .req_sprite_height (req_sprite_height),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void clear_free_list();
      free_list[0] = '{x: '0, y: '0, w: page_side, h: page_side};
      free_total = 1;
   endfunction

   function automatic void apply_page(input logic [SIZE_W-1:0] value);
      page_side = value;
      if (value == '0) begin
         page_side = SIZE_W'(1);
      end else if (value > PAGE_MAX) begin
         page_side = PAGE_MAX;
      end
      clear_free_list();
   endfunction

   // smallest fitting area, first index wins a tie; -1 when nothing fits
   function automatic int best_fit(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      int     pick;
      longint best_area;
      longint area;
      pick = -1;
      best_area = 0;
      for (int i = 0; i < free_total; i++) begin
         if (free_list[i].w >= w && free_list[i].h >= h) begin
            area = longint'(free_list[i].w) * longint'(free_list[i].h);
            if (pick < 0 || area < best_area) begin
               pick = i;
               best_area = area;
            end
         end
      end
      return pick;
   endfunction

   function automatic bit splits_both(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      int pick;
      pick = best_fit(w, h);
      if (pick < 0) begin
         return 1'b0;
      end
      return free_list[pick].w != w && free_list[pick].h != h;
   endfunction

   function automatic placement_type predict_placement(input logic c,
                                                       input logic [SIZE_W-1:0] w,
                                                       input logic [SIZE_W-1:0] h);
      placement_type res;
      free_rect_type r;
      int            pick;
      int            grown;
      int            slot;
      logic          wdiff;
      logic          hdiff;
      res = '0;
      if (c == CMD_CLEAR) begin
         clear_free_list();
         res.status = STAT_CLEARED;
      end else if (w == '0 || h == '0) begin
         res.status = STAT_ZERO;
      end else if (w > page_side || h > page_side) begin
         res.status = STAT_OVER;
      end else begin
         pick = best_fit(w, h);
         if (pick < 0) begin
            res.status = STAT_NOFIT;
         end else begin
            r = free_list[pick];
            wdiff = (r.w != w);
            hdiff = (r.h != h);
            grown = free_total + int'(wdiff) + int'(hdiff) - ((wdiff && hdiff) ? 0 : 1);
            if (grown > RECT_SLOTS) begin
               res.status = STAT_FULL;
            end else begin
               slot = free_total;
               if (wdiff && hdiff) begin
                  free_list[pick] = '{x: r.x + w, y: r.y + h, w: r.w - w, h: r.h - h};
               end else begin
                  // move the last entry into the used slot
                  free_list[pick] = free_list[slot - 1];
                  slot--;
               end
               if (wdiff) begin
                  free_list[slot] = '{x: r.x + w, y: r.y, w: r.w - w, h: h};
                  slot++;
               end
               if (hdiff) begin
                  free_list[slot] = '{x: r.x, y: r.y + h, w: w, h: r.h - h};
                  slot++;
               end
               free_total = slot;
               res.status = STAT_PLACED;
               res.pos_x = r.x[POS_W-1:0];
               res.pos_y = r.y[POS_W-1:0];
            end
         end
      end
      return res;
   endfunction

   task automatic send_item(input logic c, input logic [SIZE_W-1:0] w,
                            input logic [SIZE_W-1:0] h, input logic given,
                            input placement_type want, output placement_type predicted);
      int gap;
      gap = eager ? 0 : $urandom_range(9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_sprite_width <= w;
      req_sprite_height <= h;
      do @(posedge clock); while (!req_ready);
      predicted = predict_placement(c, w, h);
      awaited_q = {awaited_q, (given ? want : predicted)};
   endtask

   // hold off until every result is back and the block has gone quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      while (awaited_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_page(input logic [SIZE_W-1:0] value);
      settle_block();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      apply_page(value);
   endtask

   // try to pick sprites that split in both directions until the list overflows four times or 200 items are sent
   task automatic fill_free_list();
      placement_type     outcome;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      int                fulls;
      int                tries;
      fulls = 0;
      for (int n = 0; n < 200 && fulls < 4; n++) begin
         tries = 0;
         do begin
            w = SIZE_W'($urandom_range(1, 32));
            h = SIZE_W'($urandom_range(1, 32));
            tries++;
         end while (!splits_both(w, h) && tries < 64);
         send_item(CMD_ALLOC, w, h, 1'b0, '0, outcome);
         if (outcome.status == STAT_FULL) begin
            fulls++;
         end
      end
   endtask

   task automatic random_burst(input int count);
      placement_type     outcome;
      logic              c;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      int                roll;
      int                reach;
      eager = ($urandom_range(3) == 0);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         c = CMD_ALLOC;
         reach = (page_side < 24) ? int'(page_side) : 24;
         w = SIZE_W'($urandom_range(1, reach));
         h = SIZE_W'($urandom_range(1, reach));
         if (roll < 1) begin
            c = CMD_CLEAR;
            w = SIZE_W'($urandom);
            h = SIZE_W'($urandom);
         end else if (roll < 5) begin
            w = SIZE_W'($urandom);
            h = SIZE_W'($urandom);
         end else if (roll < 8) begin
            if (roll[0]) begin
               w = '0;
            end else begin
               h = '0;
            end
         end else if (roll < 11) begin
            if (roll[0]) begin
               w = SIZE_W'($urandom_range(int'(page_side) + 1, 4095));
            end else begin
               h = SIZE_W'($urandom_range(int'(page_side) + 1, 4095));
            end
         end else if (roll < 18) begin
            w = SIZE_W'($urandom_range(1, page_side));
            h = SIZE_W'($urandom_range(1, page_side));
         end else if (roll < 21) begin
            w = page_side - SIZE_W'($urandom_range(0, reach - 1));
            h = page_side;
         end
         send_item(c, w, h, 1'b0, '0, outcome);
      end
   endtask

   initial begin : stimulus
      placement_type outcome;
      directed_rows = '{
         '{CMD_ALLOC, 12'd0,    12'd5,    1'b1, '{STAT_ZERO,    11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd5,    12'd0,    1'b1, '{STAT_ZERO,    11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd0,    12'd0,    1'b1, '{STAT_ZERO,    11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd4095, 12'd1,    1'b1, '{STAT_OVER,    11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd1,    12'd2049, 1'b1, '{STAT_OVER,    11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd2049, 12'd2049, 1'b1, '{STAT_OVER,    11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd2048, 12'd2048, 1'b1, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd1,    12'd1,    1'b1, '{STAT_NOFIT,   11'd0, 11'd0}},
         '{CMD_CLEAR, 12'd4095, 12'd4095, 1'b1, '{STAT_CLEARED, 11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd1,    12'd2048, 1'b1, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd2047, 12'd2048, 1'b1, '{STAT_PLACED,  11'd1, 11'd0}},
         '{CMD_ALLOC, 12'd1,    12'd1,    1'b1, '{STAT_NOFIT,   11'd0, 11'd0}},
         '{CMD_CLEAR, 12'd0,    12'd0,    1'b1, '{STAT_CLEARED, 11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd2048, 12'd1,    1'b1, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd100,  12'd200,  1'b0, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd1948, 12'd200,  1'b0, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd2048, 12'd1847, 1'b0, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd1,    12'd1,    1'b0, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd2047, 12'd2047, 1'b0, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd4095, 12'd4095, 1'b1, '{STAT_OVER,    11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd2,    12'd3,    1'b0, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd3,    12'd2,    1'b0, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd1024, 12'd1024, 1'b0, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_ALLOC, 12'd2048, 12'd2048, 1'b0, '{STAT_PLACED,  11'd0, 11'd0}},
         '{CMD_CLEAR, 12'd4095, 12'd0,    1'b1, '{STAT_CLEARED, 11'd0, 11'd0}}
      };
      page_plan = '{12'd0, 12'd1, 12'd2, 12'd4095, 12'd2049, 12'd9, 12'd300,
                    SIZE_W'($urandom_range(1, 2048)), 12'd2048, SIZE_W'($urandom)};
      apply_page(PAGE_MAX);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_item(directed_rows[i].cmd, directed_rows[i].w, directed_rows[i].h,
                   directed_rows[i].given, directed_rows[i].want, outcome);
      end

      write_page(PAGE_MAX);
      fill_free_list();
      random_burst(140);
      for (int p = 0; p < PLAN_COUNT; p++) begin
         write_page(page_plan[p]);
         random_burst(110);
      end

      settle_block();
      repeat (20) @(posedge clock);
      if (faults == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : response_side
      placement_type want;
      int            stall;
      int            seen;
      bit            eager_rx;
      seen = 0;
      eager_rx = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (seen % 64 == 0) begin
            eager_rx = ($urandom_range(2) == 0);
         end
         stall = eager_rx ? 0 : $urandom_range(9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         seen++;
         if (awaited_q.size() == 0) begin
            $display("%0t: unexpected result: status %0d, pos %0d,%0d", $time, rsp_status,
                     rsp_pos_x, rsp_pos_y);
            faults++;
         end else begin
            want = awaited_q.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: rsp_status expected %0d, got %0d", $time, want.status,
                        rsp_status);
               faults++;
            end
            if (rsp_pos_x !== want.pos_x) begin
               $display("%0t: rsp_pos_x expected %0d, got %0d", $time, want.pos_x, rsp_pos_x);
               faults++;
            end
            if (rsp_pos_y !== want.pos_y) begin
               $display("%0t: rsp_pos_y expected %0d, got %0d", $time, want.pos_y, rsp_pos_y);
               faults++;
            end
         end
      end
   end

   // end the run if no item moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

// File: filelist.f
src/afra_pkg.sv
src/afra_rect_mem.sv
src/afra_fit_unit.sv
src/afra_seq.sv
src/atlas_free_rect_allocator.sv
verif/tb.sv
